// ===== hw/rtl/address_range_table_macros.svh =====
// assertion macros used by the address range table engine
`ifndef ADDRESS_RANGE_TABLE_MACROS_SVH
`define ADDRESS_RANGE_TABLE_MACROS_SVH

// property holds at every rising clock edge out of reset
`define ART_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("address_range_table assertion failed");

// consequent holds in the cycle after the antecedent
`define ART_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("address_range_table assertion failed");

`endif

// ===== hw/rtl/art_pkg.sv =====
// shared types and constants of the address range table
`timescale 1ns / 1ps

package art_pkg;

	localparam int DEF_MAX_ENTRIES = 64;
	localparam int DEF_ADDR_BITS   = 48;
	localparam int QUEUE_DEPTH     = 2;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_LOOKUP = 2'd2,
		OP_GAP    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_OVERLAP = 2'd2,
		ST_MISS    = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		ENG_IDLE,
		ENG_SCAN,
		ENG_SHIFT,
		ENG_WRNEW,
		ENG_DONE
	} eng_state_t;

	// decoded control part of one queued command
	typedef struct packed {
		op_t  op;
		logic bad_range;
	} cmd_ctrl_t;

	localparam int CTRL_W = $bits(cmd_ctrl_t);

endpackage

// ===== hw/rtl/art_ram.sv =====
// generic single write port memory with registered read
`timescale 1ns / 1ps

module art_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== hw/rtl/art_queue.sv =====
// small command fifo between front end and engine
`timescale 1ns / 1ps

module art_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = art_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             not_empty
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full      = (cnt_q == FULL_CNT);
	assign not_empty = (cnt_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign pop_data  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/art_front.sv =====
// front end: decodes and packs incoming items into commands
`timescale 1ns / 1ps

module art_front #(
	parameter int ADDR_BITS = art_pkg::DEF_ADDR_BITS
) (
	input  logic [1:0]               mode,
	input  logic [ADDR_BITS-1:0]     range_start,
	input  logic [ADDR_BITS-1:0]     range_end,
	input  logic [2:0]               range_perms,
	input  logic [ADDR_BITS-1:0]     lookup_address,
	input  logic [ADDR_BITS-1:0]     gap_size,
	input  logic [ADDR_BITS-1:0]     base_hint,
	output art_pkg::cmd_ctrl_t       ctrl,
	output logic [3*ADDR_BITS+2:0]   data
);

	logic [ADDR_BITS-1:0] key_a;
	logic [ADDR_BITS-1:0] key_b;

	always_comb begin
		ctrl.op        = art_pkg::op_t'(mode);
		// empty or inverted insert range is rejected without a table walk
		ctrl.bad_range = (ctrl.op == art_pkg::OP_INSERT) && (range_end <= range_start);
		key_a = (ctrl.op == art_pkg::OP_LOOKUP) ? lookup_address : range_start;
		key_b = (ctrl.op == art_pkg::OP_GAP) ? gap_size : range_end;
	end

	assign data = {key_a, key_b, base_hint, range_perms};

endmodule

// ===== hw/rtl/art_engine.sv =====
// back end: walks and edits the sorted range table, holds the result
`timescale 1ns / 1ps
`include "address_range_table_macros.svh"

module art_engine #(
	parameter int MAX_ENTRIES = art_pkg::DEF_MAX_ENTRIES,
	parameter int ADDR_BITS   = art_pkg::DEF_ADDR_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [ADDR_BITS-1:0]   min_base,
	input  logic                   cq_valid,
	input  art_pkg::cmd_ctrl_t     cq_ctrl,
	input  logic [3*ADDR_BITS+2:0] cq_data,
	output logic                   cq_pop,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [1:0]             status,
	output logic [ADDR_BITS-1:0]   hit_start,
	output logic [ADDR_BITS-1:0]   hit_end,
	output logic [2:0]             hit_perms,
	output logic [ADDR_BITS-1:0]   free_addr
);

	localparam int IDX_W = $clog2(MAX_ENTRIES);
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int ENT_W = 2 * ADDR_BITS + 3;
	localparam int CMD_W = 3 * ADDR_BITS + 3;
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_ENTRIES);
	localparam logic [CNT_W-1:0] ONE      = CNT_W'(1);

	art_pkg::eng_state_t state_q, state_nx;

	// latched command
	art_pkg::op_t         op_q;
	logic [ADDR_BITS-1:0] a_q, b_q, c_q;
	logic [2:0]           perms_q;

	logic [CNT_W-1:0]     cnt_q;

	// table walk
	logic [CNT_W-1:0]     rd_idx_q;
	logic                 dv_q;
	logic [IDX_W-1:0]     di_q;
	logic [CNT_W-1:0]     pos_q;
	logic                 pos_found_q;
	logic [ADDR_BITS-1:0] prev_lim_q;

	// entry move
	logic [CNT_W-1:0]     sh_ptr_q, sh_left_q;
	logic                 sh_up_q, sh_pv_q;
	logic [IDX_W-1:0]     sh_wa_q;

	// finished result and output register
	art_pkg::status_t     rst_q;
	logic [ADDR_BITS-1:0] rhs_q, rhe_q, rfa_q;
	logic [2:0]           rhp_q;
	logic                 out_valid_q;
	art_pkg::status_t     out_status_q;
	logic [ADDR_BITS-1:0] out_hs_q, out_he_q, out_fa_q;
	logic [2:0]           out_hp_q;

	// memory port
	logic                 mem_we;
	logic [IDX_W-1:0]     mem_waddr, mem_raddr;
	logic [ENT_W-1:0]     mem_wdata, mem_rdata;

	// walk evaluation
	logic [ADDR_BITS-1:0] rb, rl, gap_ref, gap_diff;
	logic [2:0]           rp;
	logic                 scan_issue, scan_end, stop, hint_ok, gap_hit;
	logic                 slot_free;
	logic [CNT_W-1:0]     pos_eff;

	assign rb = mem_rdata[ADDR_BITS-1:0];
	assign rl = mem_rdata[2*ADDR_BITS-1:ADDR_BITS];
	assign rp = mem_rdata[ENT_W-1:2*ADDR_BITS];

	art_ram #(
		.WIDTH(ENT_W),
		.DEPTH(MAX_ENTRIES)
	) u_table (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// outputs of the state machine and walk evaluation
	always_comb begin
		slot_free  = !out_valid_q || out_ready;
		cq_pop     = (state_q == art_pkg::ENG_IDLE) && cq_valid;
		scan_issue = (state_q == art_pkg::ENG_SCAN) && (rd_idx_q < cnt_q);
		scan_end   = (state_q == art_pkg::ENG_SCAN) && (rd_idx_q >= cnt_q) && !dv_q;
		gap_ref    = (di_q == '0) ? c_q : prev_lim_q;
		gap_diff   = rb - gap_ref;
		hint_ok    = (c_q != '0) && (c_q >= min_base) && (rb > c_q) && (gap_diff >= b_q);
		gap_hit    = (di_q == '0) ? hint_ok : (gap_diff >= b_q);
		pos_eff    = pos_found_q ? pos_q : cnt_q;
		stop       = 1'b0;
		if ((state_q == art_pkg::ENG_SCAN) && dv_q) begin
			unique case (op_q)
				art_pkg::OP_INSERT: stop = (rb < b_q) && (rl > a_q);
				art_pkg::OP_REMOVE: stop = (rb == a_q) && (rl == b_q);
				art_pkg::OP_LOOKUP: stop = (rb <= a_q) && (rl > a_q);
				art_pkg::OP_GAP:    stop = gap_hit;
				default:            stop = 1'b0;
			endcase
		end
		mem_raddr = (state_q == art_pkg::ENG_SCAN) ? rd_idx_q[IDX_W-1:0]
			: sh_ptr_q[IDX_W-1:0];
		mem_we    = 1'b0;
		mem_waddr = sh_wa_q;
		mem_wdata = mem_rdata;
		if (state_q == art_pkg::ENG_SHIFT) begin
			mem_we = sh_pv_q;
		end else if (state_q == art_pkg::ENG_WRNEW) begin
			mem_we    = 1'b1;
			mem_waddr = pos_q[IDX_W-1:0];
			mem_wdata = {perms_q, b_q, a_q};
		end
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			art_pkg::ENG_IDLE: begin
				if (cq_valid) begin
					state_nx = cq_ctrl.bad_range ? art_pkg::ENG_DONE : art_pkg::ENG_SCAN;
				end
			end
			art_pkg::ENG_SCAN: begin
				if (stop) begin
					state_nx = (op_q == art_pkg::OP_REMOVE) ? art_pkg::ENG_SHIFT
						: art_pkg::ENG_DONE;
				end else if (scan_end) begin
					state_nx = ((op_q == art_pkg::OP_INSERT) && (cnt_q != FULL_CNT))
						? art_pkg::ENG_SHIFT : art_pkg::ENG_DONE;
				end
			end
			art_pkg::ENG_SHIFT: begin
				if ((sh_left_q == '0) && !sh_pv_q) begin
					state_nx = sh_up_q ? art_pkg::ENG_WRNEW : art_pkg::ENG_DONE;
				end
			end
			art_pkg::ENG_WRNEW: state_nx = art_pkg::ENG_DONE;
			art_pkg::ENG_DONE: begin
				if (slot_free) begin
					state_nx = art_pkg::ENG_IDLE;
				end
			end
			default: state_nx = art_pkg::ENG_IDLE;
		endcase
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cq_pop) begin
			op_q    <= cq_ctrl.op;
			a_q     <= cq_data[CMD_W-1 -: ADDR_BITS];
			b_q     <= cq_data[CMD_W-1-ADDR_BITS -: ADDR_BITS];
			c_q     <= cq_data[ADDR_BITS+2:3];
			perms_q <= cq_data[2:0];
			rst_q   <= cq_ctrl.bad_range ? art_pkg::ST_OVERLAP : art_pkg::ST_OK;
			rhs_q   <= '0;
			rhe_q   <= '0;
			rhp_q   <= '0;
			rfa_q   <= '0;
			pos_found_q <= 1'b0;
		end
		if (scan_issue) begin
			di_q <= rd_idx_q[IDX_W-1:0];
		end
		if ((state_q == art_pkg::ENG_SCAN) && dv_q) begin
			prev_lim_q <= rl;
			if ((op_q == art_pkg::OP_INSERT) && !pos_found_q && (b_q <= rb)) begin
				pos_q       <= CNT_W'(di_q);
				pos_found_q <= 1'b1;
			end
		end
		if (stop) begin
			unique case (op_q)
				art_pkg::OP_INSERT: rst_q <= art_pkg::ST_OVERLAP;
				art_pkg::OP_REMOVE: begin
					sh_up_q   <= 1'b0;
					sh_ptr_q  <= CNT_W'(di_q) + ONE;
					sh_left_q <= cnt_q - ONE - CNT_W'(di_q);
				end
				art_pkg::OP_LOOKUP: begin
					rhs_q <= rb;
					rhe_q <= rl;
					rhp_q <= rp;
				end
				art_pkg::OP_GAP: rfa_q <= gap_ref;
				default: rst_q <= art_pkg::ST_OK;
			endcase
		end else if (scan_end) begin
			if (op_q == art_pkg::OP_INSERT) begin
				if (cnt_q == FULL_CNT) begin
					rst_q <= art_pkg::ST_FULL;
				end else begin
					sh_up_q   <= 1'b1;
					sh_ptr_q  <= cnt_q - ONE;
					sh_left_q <= cnt_q - pos_eff;
					pos_q     <= pos_eff;
				end
			end else begin
				rst_q <= art_pkg::ST_MISS;
			end
		end
		if ((state_q == art_pkg::ENG_SHIFT) && (sh_left_q != '0)) begin
			sh_ptr_q  <= sh_up_q ? sh_ptr_q - ONE : sh_ptr_q + ONE;
			sh_left_q <= sh_left_q - ONE;
			sh_wa_q   <= sh_up_q ? IDX_W'(sh_ptr_q + ONE) : IDX_W'(sh_ptr_q - ONE);
		end
		if ((state_q == art_pkg::ENG_DONE) && slot_free) begin
			out_status_q <= rst_q;
			out_hs_q     <= rhs_q;
			out_he_q     <= rhe_q;
			out_hp_q     <= rhp_q;
			out_fa_q     <= rfa_q;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= art_pkg::ENG_IDLE;
			cnt_q       <= '0;
			rd_idx_q    <= '0;
			dv_q        <= 1'b0;
			sh_pv_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cq_pop) begin
				rd_idx_q <= '0;
			end else if (scan_issue) begin
				rd_idx_q <= rd_idx_q + ONE;
			end
			dv_q    <= scan_issue && !stop;
			sh_pv_q <= (state_q == art_pkg::ENG_SHIFT) && (sh_left_q != '0);
			if (state_q == art_pkg::ENG_WRNEW) begin
				cnt_q <= cnt_q + ONE;
			end else if ((state_q == art_pkg::ENG_SHIFT) && !sh_up_q
				&& (state_nx == art_pkg::ENG_DONE)) begin
				cnt_q <= cnt_q - ONE;
			end
			if ((state_q == art_pkg::ENG_DONE) && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign status    = out_status_q;
	assign hit_start = out_hs_q;
	assign hit_end   = out_he_q;
	assign hit_perms = out_hp_q;
	assign free_addr = out_fa_q;

	`ART_ASSERT(a_cnt_bound, clk, arst_n, cnt_q <= FULL_CNT)
	`ART_ASSERT(a_we_state, clk, arst_n, !mem_we || (state_q == art_pkg::ENG_SHIFT) || (state_q == art_pkg::ENG_WRNEW))
	`ART_ASSERT_NEXT(a_ins_cnt, clk, arst_n, state_q == art_pkg::ENG_WRNEW, cnt_q == $past(cnt_q) + ONE)
	`ART_ASSERT_NEXT(a_res_out, clk, arst_n, (state_q == art_pkg::ENG_DONE) && slot_free, out_valid_q)

endmodule

// ===== hw/rtl/address_range_table.sv =====
// top level of the sorted address range table
`timescale 1ns / 1ps
// usage
//   in_valid/in_ready takes one command item: mode selects insert, remove,
//   lookup or free gap search, the other fields are its operands
//   out_valid/out_ready returns exactly one result item per command, in order
//   cfg_valid/cfg_ready writes min_base_addr (lowest accepted base hint);
//   cfg_ready is always high, write only while no command is in flight
// timing
//   a command crosses a two entry queue, then the engine walks the table
//   one entry per cycle through the table memory's single read port
//   for insert and remove, entries then move one per cycle to keep the
//   table sorted
//   one command is in the engine at a time; the next one can be taken in
//   the cycle after a result is loaded, the front takes items while the queue has room
// reset
//   the table is empty and min_base_addr is 0; no clearing pass is needed
// back pressure
//   a result waits in the engine until the output register is taken,
//   the queue then fills and in_ready drops
module address_range_table #(
	parameter int MAX_ENTRIES = art_pkg::DEF_MAX_ENTRIES,
	parameter int ADDR_BITS   = art_pkg::DEF_ADDR_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [ADDR_BITS-1:0] cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           mode,
	input  logic [ADDR_BITS-1:0] range_start,
	input  logic [ADDR_BITS-1:0] range_end,
	input  logic [2:0]           range_perms,
	input  logic [ADDR_BITS-1:0] lookup_address,
	input  logic [ADDR_BITS-1:0] gap_size,
	input  logic [ADDR_BITS-1:0] base_hint,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [1:0]           status,
	output logic [ADDR_BITS-1:0] hit_start,
	output logic [ADDR_BITS-1:0] hit_end,
	output logic [2:0]           hit_perms,
	output logic [ADDR_BITS-1:0] free_addr
);

	localparam int DATA_W = 3 * ADDR_BITS + 3;
	localparam int QW     = art_pkg::CTRL_W + DATA_W;

	// configuration register
	logic [ADDR_BITS-1:0] min_base_q;

	// front end outputs
	art_pkg::cmd_ctrl_t   fe_ctrl;
	logic [DATA_W-1:0]    fe_data;

	// queue head
	logic                 q_full;
	logic                 q_not_empty;
	logic                 q_pop;
	logic [QW-1:0]        q_head;
	art_pkg::cmd_ctrl_t   q_ctrl;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_base_q <= '0;
		end else if (cfg_valid) begin
			min_base_q <= cfg_data;
		end
	end

	// decode and pack the item
	art_front #(
		.ADDR_BITS(ADDR_BITS)
	) u_front (
		.mode          (mode),
		.range_start   (range_start),
		.range_end     (range_end),
		.range_perms   (range_perms),
		.lookup_address(lookup_address),
		.gap_size      (gap_size),
		.base_hint     (base_hint),
		.ctrl          (fe_ctrl),
		.data          (fe_data)
	);

	// decouples the front from the table walk
	assign in_ready = !q_full;

	art_queue #(
		.WIDTH(QW),
		.DEPTH(art_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (in_valid),
		.push_data({fe_ctrl, fe_data}),
		.full     (q_full),
		.pop      (q_pop),
		.pop_data (q_head),
		.not_empty(q_not_empty)
	);

	assign q_ctrl = art_pkg::cmd_ctrl_t'(q_head[QW-1:DATA_W]);

	// table walker and result register
	art_engine #(
		.MAX_ENTRIES(MAX_ENTRIES),
		.ADDR_BITS  (ADDR_BITS)
	) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.min_base (min_base_q),
		.cq_valid (q_not_empty),
		.cq_ctrl  (q_ctrl),
		.cq_data  (q_head[DATA_W-1:0]),
		.cq_pop   (q_pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status   (status),
		.hit_start(hit_start),
		.hit_end  (hit_end),
		.hit_perms(hit_perms),
		.free_addr(free_addr)
	);

endmodule

// ===== dv/tb_top.sv =====
// self-checking testbench for the sorted address range table
`timescale 1ns / 1ps

module tb_top;
	import art_pkg::*;

	localparam int NENT  = 64;
	localparam int AW    = 48;
	localparam longint unsigned LIMIT = 2000000;

	typedef logic [AW-1:0] addr_t;

	// one command item as driven on the input channel
	typedef struct {
		op_t       op;
		addr_t     rs;
		addr_t     re;
		logic [2:0] perms;
		addr_t     la;
		addr_t     gs;
		addr_t     bh;
		bit        has_exp;
		status_t   x_status;
		addr_t     x_free;
	} cmd_t;

	// one result item
	typedef struct {
		status_t    st;
		addr_t      hs;
		addr_t      he;
		logic [2:0] hp;
		addr_t      fa;
	} res_t;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_valid = 0;
	logic cfg_ready;
	addr_t cfg_data = '0;
	logic in_valid = 0;
	logic in_ready;
	logic [1:0] mode = '0;
	addr_t range_start = '0, range_end = '0, lookup_address = '0;
	addr_t gap_size = '0, base_hint = '0;
	logic [2:0] range_perms = '0;
	logic out_valid;
	logic out_ready = 0;
	logic [1:0] status;
	addr_t hit_start, hit_end, free_addr;
	logic [2:0] hit_perms;

	address_range_table dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .mode(mode),
		.range_start(range_start), .range_end(range_end),
		.range_perms(range_perms), .lookup_address(lookup_address),
		.gap_size(gap_size), .base_hint(base_hint),
		.out_valid(out_valid), .out_ready(out_ready), .status(status),
		.hit_start(hit_start), .hit_end(hit_end), .hit_perms(hit_perms),
		.free_addr(free_addr)
	);

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	// shadow copy of the table held by the predictor
	addr_t      tbl_lo[NENT];
	addr_t      tbl_hi[NENT];
	logic [2:0] tbl_perm[NENT];
	int         tbl_n;
	addr_t      min_base;

	res_t pending_results[$];
	int   errors;
	longint unsigned cycles;
	bit   drain_mode;

	task automatic report(input string what, input logic [63:0] got,
		input logic [63:0] want);
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// apply one command to the shadow table and return its result
	function automatic res_t table_apply(input cmd_t c);
		res_t r;
		int pos, i, j;
		bit done;
		r = '{ST_OK, '0, '0, '0, '0};
		case (c.op)
			OP_INSERT: begin
				pos = tbl_n;
				done = 0;
				if (c.re <= c.rs) begin
					r.st = ST_OVERLAP;
					done = 1;
				end
				for (i = 0; i < tbl_n && !done; i++) begin
					if (tbl_lo[i] < c.re && tbl_hi[i] > c.rs) begin
						r.st = ST_OVERLAP;
						done = 1;
					end else if (pos == tbl_n && c.re <= tbl_lo[i]) pos = i;
				end
				if (!done && tbl_n >= NENT) begin
					r.st = ST_FULL;
					done = 1;
				end
				if (!done) begin
					for (i = tbl_n; i > pos; i--) begin
						tbl_lo[i] = tbl_lo[i-1];
						tbl_hi[i] = tbl_hi[i-1];
						tbl_perm[i] = tbl_perm[i-1];
					end
					tbl_lo[pos] = c.rs;
					tbl_hi[pos] = c.re;
					tbl_perm[pos] = c.perms;
					tbl_n++;
				end
			end
			OP_REMOVE: begin
				r.st = ST_MISS;
				for (i = 0; i < tbl_n; i++) begin
					if (tbl_lo[i] == c.rs && tbl_hi[i] == c.re) begin
						for (j = i; j + 1 < tbl_n; j++) begin
							tbl_lo[j] = tbl_lo[j+1];
							tbl_hi[j] = tbl_hi[j+1];
							tbl_perm[j] = tbl_perm[j+1];
						end
						tbl_n--;
						r.st = ST_OK;
						break;
					end
				end
			end
			OP_LOOKUP: begin
				r.st = ST_MISS;
				for (i = 0; i < tbl_n; i++) begin
					if (tbl_lo[i] <= c.la && tbl_hi[i] > c.la) begin
						r.st = ST_OK;
						r.hs = tbl_lo[i];
						r.he = tbl_hi[i];
						r.hp = tbl_perm[i];
						break;
					end
				end
			end
			default: begin
				done = 0;
				if (tbl_n > 0) begin
					if (c.bh != 0 && c.bh >= min_base && tbl_lo[0] > c.bh &&
						addr_t'(tbl_lo[0] - c.bh) >= c.gs) begin
						r.fa = c.bh;
						done = 1;
					end
					for (i = 0; i + 1 < tbl_n && !done; i++) begin
						if (addr_t'(tbl_lo[i+1] - tbl_hi[i]) >= c.gs) begin
							r.fa = tbl_hi[i];
							done = 1;
						end
					end
				end
				r.st = (r.fa != 0) ? ST_OK : ST_MISS;
			end
		endcase
		return r;
	endfunction

	// output side: random stalls, each result checked against the oldest one
	initial begin
		res_t w;
		int stall;
		@(posedge arst_n);
		forever begin
			stall = $urandom_range(0, 6);
			if ($urandom_range(0, 3) == 0) stall = 0;
			if (stall > 0) begin
				out_ready <= 0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			if (pending_results.size() == 0) begin
				report("unexpected item", 64'(status), 64'(0));
			end else begin
				w = pending_results.pop_front();
				if (status !== w.st) report("status", 64'(status), 64'(w.st));
				if (hit_start !== w.hs) report("hit_start", 64'(hit_start), 64'(w.hs));
				if (hit_end !== w.he) report("hit_end", 64'(hit_end), 64'(w.he));
				if (hit_perms !== w.hp) report("hit_perms", 64'(hit_perms), 64'(w.hp));
				if (free_addr !== w.fa) report("free_addr", 64'(free_addr), 64'(w.fa));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	// send one command, predicting its result at acceptance
	// in_valid stays high after acceptance until the caller moves on
	task automatic send_cmd(input cmd_t c);
		res_t r;
		int gap;
		gap = $urandom_range(0, 6);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		mode <= c.op;
		range_start <= c.rs;
		range_end <= c.re;
		range_perms <= c.perms;
		lookup_address <= c.la;
		gap_size <= c.gs;
		base_hint <= c.bh;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		r = table_apply(c);
		// typed-in rows are checked against their own value as well
		if (c.has_exp && (r.st !== c.x_status || r.fa !== c.x_free))
			report("table row", 64'(r.st), 64'(c.x_status));
		pending_results.push_back(r);
	endtask

	task automatic write_min_base(input addr_t v);
		in_valid <= 0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		cfg_valid <= 1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		min_base = v;
		cfg_valid <= 0;
	endtask

	function automatic cmd_t mk(input op_t op, input addr_t rs, input addr_t re,
		input logic [2:0] p, input addr_t la, input addr_t gs, input addr_t bh);
		cmd_t c;
		c = '{op, rs, re, p, la, gs, bh, 0, ST_OK, '0};
		return c;
	endfunction

	function automatic cmd_t mkx(input cmd_t c, input status_t s, input addr_t fa);
		c.has_exp = 1;
		c.x_status = s;
		c.x_free = fa;
		return c;
	endfunction

	// random command biased toward a small address window so ranges collide
	function automatic cmd_t rand_cmd(input int wide);
		cmd_t c;
		addr_t a, len;
		int k;
		c = mk(op_t'($urandom_range(0, 3)), '0, '0, 3'($urandom), '0, '0, '0);
		if (wide) begin
			a = addr_t'({$urandom, $urandom});
			len = addr_t'({$urandom, $urandom});
		end else begin
			a = addr_t'($urandom_range(0, 4000));
			len = addr_t'($urandom_range(1, 60));
		end
		c.rs = a;
		c.re = a + len;
		if ($urandom_range(0, 19) == 0) c.re = a - addr_t'($urandom_range(0, 3));
		if (c.op == OP_REMOVE && tbl_n > 0 && $urandom_range(0, 1)) begin
			k = $urandom_range(0, tbl_n - 1);
			c.rs = tbl_lo[k];
			c.re = tbl_hi[k];
		end
		c.la = wide ? addr_t'({$urandom, $urandom}) : addr_t'($urandom_range(0, 4100));
		c.gs = wide ? addr_t'({$urandom, $urandom}) : addr_t'($urandom_range(0, 80));
		c.bh = ($urandom_range(0, 3) == 0) ? '0 :
			(wide ? addr_t'({$urandom, $urandom}) : addr_t'($urandom_range(0, 400)));
		return c;
	endfunction

	initial begin
		cmd_t dir_rows[$];
		addr_t mx;
		int i, ph;
		mx = '1;
		errors = 0;
		cycles = 0;
		tbl_n = 0;
		min_base = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed table: empty-table cases, extremes, every operation
		dir_rows.push_back(mkx(mk(OP_LOOKUP, 0, 0, 0, 0, 0, 0), ST_MISS, 0));
		dir_rows.push_back(mkx(mk(OP_GAP, 0, 0, 0, 0, 0, 5), ST_MISS, 0));
		dir_rows.push_back(mkx(mk(OP_REMOVE, 1, 2, 0, 0, 0, 0), ST_MISS, 0));
		// malformed insert, equal and reversed ends
		dir_rows.push_back(mkx(mk(OP_INSERT, 10, 10, 7, 0, 0, 0), ST_OVERLAP, 0));
		dir_rows.push_back(mkx(mk(OP_INSERT, mx, 0, 7, 0, 0, 0), ST_OVERLAP, 0));
		dir_rows.push_back(mkx(mk(OP_INSERT, 1000, 2000, 5, 0, 0, 0), ST_OK, 0));
		// single range has no gap between ranges
		dir_rows.push_back(mkx(mk(OP_GAP, 0, 0, 0, 0, 1, 0), ST_MISS, 0));
		dir_rows.push_back(mk(OP_INSERT, 0, 1, 1, 0, 0, 0));
		dir_rows.push_back(mk(OP_INSERT, mx - 1, mx, 6, 0, 0, 0));
		dir_rows.push_back(mkx(mk(OP_INSERT, 1500, 2500, 2, 0, 0, 0), ST_OVERLAP, 0));
		dir_rows.push_back(mk(OP_INSERT, 2000, 3000, 3, 0, 0, 0));
		dir_rows.push_back(mk(OP_LOOKUP, 0, 0, 0, 1999, 0, 0));
		dir_rows.push_back(mk(OP_LOOKUP, 0, 0, 0, mx - 1, 0, 0));
		dir_rows.push_back(mk(OP_LOOKUP, 0, 0, 0, mx, 0, 0));
		// hint accepted below the first range is impossible when it starts at 0
		dir_rows.push_back(mk(OP_GAP, 0, 0, 0, 0, 0, 0));
		dir_rows.push_back(mk(OP_GAP, 0, 0, 0, 0, mx, mx));
		dir_rows.push_back(mk(OP_GAP, 0, 0, 0, 0, 999, 1));
		dir_rows.push_back(mkx(mk(OP_REMOVE, 1000, 1999, 0, 0, 0, 0), ST_MISS, 0));
		dir_rows.push_back(mkx(mk(OP_REMOVE, 0, 1, 0, 0, 0, 0), ST_OK, 0));
		// hint fits now that the table starts at 1000
		dir_rows.push_back(mkx(mk(OP_GAP, 0, 0, 0, 0, 500, 400), ST_OK, 400));
		dir_rows.push_back(mk(OP_GAP, 0, 0, 0, 0, 700, 400));
		foreach (dir_rows[i]) send_cmd(dir_rows[i]);

		// min base above the hint disables it
		write_min_base(addr_t'(500));
		send_cmd(mk(OP_GAP, 0, 0, 0, 0, 10, 400));
		send_cmd(mk(OP_GAP, 0, 0, 0, 0, 10, 500));

		// fill the table to capacity, then check full and overlap priority
		for (i = 0; i < NENT; i++) send_cmd(mk(OP_INSERT, addr_t'(10000 + 10*i),
			addr_t'(10005 + 10*i), 3'(i), 0, 0, 0));
		send_cmd(mk(OP_INSERT, 10000, 10003, 0, 0, 0, 0));
		send_cmd(mk(OP_GAP, 0, 0, 0, 0, 5, 0));
		send_cmd(mk(OP_LOOKUP, 0, 0, 0, 10634, 0, 0));
		for (i = 0; i < tbl_n + 8 && tbl_n > 0; i++)
			send_cmd(mk(OP_REMOVE, tbl_lo[0], tbl_hi[0], 0, 0, 0, 0));

		// random phases across several min base settings
		for (ph = 0; ph < 5; ph++) begin
			case (ph)
				0: write_min_base('0);
				1: write_min_base(mx);
				2: write_min_base(addr_t'(150));
				3: write_min_base(addr_t'({$urandom, $urandom}));
				default: write_min_base(addr_t'(40));
			endcase
			for (i = 0; i < 120; i++) send_cmd(rand_cmd($urandom_range(0, 9) == 0));
		end

		in_valid <= 0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/art_pkg.sv
hw/rtl/art_ram.sv
hw/rtl/art_queue.sv
hw/rtl/art_front.sv
hw/rtl/art_engine.sv
hw/rtl/address_range_table.sv
dv/tb_top.sv
